>>> rtl/rbfh_pkg.sv
// Types and constants shared by the ray/box face hit block.
`default_nettype none
package rbfh_pkg;
    localparam int CW     = 32;
    localparam int FB     = 16;
    localparam int DIV_W  = 50;
    localparam int PNT_W  = 49;

    typedef logic signed [CW-1:0] t_coord;

    typedef enum logic [2:0] {
        FACE_XMIN = 3'd0,
        FACE_XMAX = 3'd1,
        FACE_YMIN = 3'd2,
        FACE_YMAX = 3'd3,
        FACE_ZMIN = 3'd4,
        FACE_ZMAX = 3'd5
    } t_face;

    localparam logic [2:0] CFG_CORNER_X = 3'd0;
    localparam logic [2:0] CFG_CORNER_Y = 3'd1;
    localparam logic [2:0] CFG_CORNER_Z = 3'd2;
    localparam logic [2:0] CFG_SIZE_X   = 3'd3;
    localparam logic [2:0] CFG_SIZE_Y   = 3'd4;
    localparam logic [2:0] CFG_SIZE_Z   = 3'd5;

    localparam logic [16:0] UV_ONE = 17'h10000;

    typedef struct packed {
        t_coord origin_x;
        t_coord origin_y;
        t_coord origin_z;
        t_coord dir_x;
        t_coord dir_y;
        t_coord dir_z;
    } t_ray;

    typedef struct packed {
        logic        hit;
        logic [2:0]  face;
        t_coord      point_x;
        t_coord      point_y;
        t_coord      point_z;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic        last;
    } t_res;

    typedef struct packed {
        logic signed [CW:0] lo;
        logic signed [CW:0] hi;
        logic [CW-2:0]      size;
    } t_axis;

    typedef t_axis [2:0] t_box;

    typedef struct packed {
        logic [2:0][CW-1:0] org;
        logic [2:0][CW-1:0] dmag;
        logic [2:0]         dneg;
        logic [5:0]         skip;
        logic [5:0][CW+1:0] nmag;
    } t_job;
endpackage
`default_nettype wire

>>> rtl/rbfh_if.sv
// Valid/ready channel carrying one payload item.
`default_nettype none
interface rbfh_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/ray_box_face_hits.sv
// Top level: box registers, front classifier, job queue and face back end.
//
//  channel   dir  handshake              payload
//  i_ray     in   valid/ready            origin_x..z, dir_x..z
//  o_res     out  valid/ready            hit, face, point_x..z, tex_u, tex_v, last
//  i_cfg     in   i_cfg_we               i_cfg_idx, i_cfg_data
//
// Each face not skipped takes a 50-step serial divide for t, up to two
// multiplies and up to two 17-step serial fraction divides. A two-entry job
// queue lets another ray enter while one is in work. Reset is synchronous;
// the box resets to the unit cube at the origin. Either side may stall at any
// time; a result waits in a pending register until the next is known, then in
// one output register.
`default_nettype none
module ray_box_face_hits import rbfh_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    rbfh_if.sink               i_ray,
    rbfh_if.source             o_res,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [CW-1:0] i_cfg_data
);
    logic [CW-1:0] r_corner [3];
    logic [CW-2:0] r_size [3];
    t_box          box;
    t_job          job;
    logic          job_valid;
    logic          job_pop;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            box[a].lo   = {r_corner[a][CW-1], r_corner[a]};
            box[a].hi   = {r_corner[a][CW-1], r_corner[a]} + {2'b00, r_size[a]};
            box[a].size = r_size[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_corner[a] <= '0;
                r_size[a]   <= (CW-1)'(1) << FB;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CORNER_X: r_corner[0] <= i_cfg_data;
                CFG_CORNER_Y: r_corner[1] <= i_cfg_data;
                CFG_CORNER_Z: r_corner[2] <= i_cfg_data;
                CFG_SIZE_X:   r_size[0]   <= i_cfg_data[CW-2:0];
                CFG_SIZE_Y:   r_size[1]   <= i_cfg_data[CW-2:0];
                CFG_SIZE_Z:   r_size[2]   <= i_cfg_data[CW-2:0];
                default: begin
                end
            endcase
        end
    end

    rbfh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ray       (i_ray),
        .i_box       (box),
        .o_job       (job),
        .o_job_valid (job_valid),
        .i_job_pop   (job_pop)
    );

    rbfh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .i_box       (box),
        .o_res       (o_res)
    );
endmodule
`default_nettype wire

>>> rtl/rbfh_front.sv
// Front part: classify each ray per face and queue the job.
`default_nettype none
module rbfh_front import rbfh_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rbfh_if.sink      i_ray,
    input  wire t_box i_box,
    output t_job      o_job,
    output logic      o_job_valid,
    input  wire logic i_job_pop
);
    t_job         n_job;
    t_job         r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         push;

    always_comb begin
        logic [2:0][CW-1:0] o;
        logic [2:0][CW-1:0] d;
        logic signed [CW:0]   plane;
        logic signed [CW+1:0] num;
        o = {i_ray.data.origin_z, i_ray.data.origin_y, i_ray.data.origin_x};
        d = {i_ray.data.dir_z, i_ray.data.dir_y, i_ray.data.dir_x};
        n_job.org = o;
        for (int a = 0; a < 3; a++) begin
            n_job.dneg[a] = d[a][CW-1];
            n_job.dmag[a] = d[a][CW-1] ? (CW'(0) - d[a]) : d[a];
            for (int s = 0; s < 2; s++) begin
                plane = (s == 1) ? i_box[a].hi : i_box[a].lo;
                num = {plane[CW], plane} - {{2{o[a][CW-1]}}, o[a]};
                n_job.skip[2*a+s] = (d[a] == '0) ||
                    ((num != '0) && (num[CW+1] != d[a][CW-1]));
                n_job.nmag[2*a+s] = num[CW+1] ? ((CW+2)'(0) - num) : num;
            end
        end
    end

    assign i_ray.ready = (r_cnt != 2'd2);
    assign push        = i_ray.valid && i_ray.ready;
    assign o_job       = r_mem[r_rp];
    assign o_job_valid = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= n_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_job_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_job_pop);
        end
    end
endmodule
`default_nettype wire

>>> rtl/rbfh_back.sv
// Back part: per-face divide, scale, inside test, texture fraction and result output.
`default_nettype none
module rbfh_back import rbfh_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_job,
    input  wire logic i_job_valid,
    output logic      o_job_pop,
    input  wire t_box i_box,
    rbfh_if.source    o_res
);
    typedef enum logic [3:0] {
        S_IDLE, S_FACE, S_TDIV, S_MUL, S_PNT, S_FDIV, S_EMIT, S_NEXT, S_DONE
    } t_state;

    t_state               r_state;
    logic [2:0]           r_face;
    logic                 r_k;
    logic [5:0]           r_cnt;
    logic [CW-1:0]        r_rem;
    logic [DIV_W-1:0]     r_q;
    logic [CW-2:0]        r_t;
    logic [2*CW-2:0]      r_prod;
    logic signed [PNT_W-1:0] r_p [3];
    logic [16:0]          r_f [3];
    logic [CW-2:0]        r_fr;
    logic [16:0]          r_fq;
    logic                 r_pend_v;
    t_res                 r_pend;
    logic                 r_ov;
    t_res                 r_out;

    logic [1:0]           a;
    logic [1:0]           b;
    logic [CW:0]          trs;
    logic                 tge;
    logic [DIV_W-1:0]     nq;
    logic signed [PNT_W-1:0] p;
    logic signed [PNT_W-1:0] lo49;
    logic signed [PNT_W-1:0] hi49;
    logic signed [PNT_W-1:0] off;
    logic                 in_box;
    logic [CW-1:0]        sz;
    logic                 ge0;
    logic [CW-1:0]        frs;
    logic                 fge;
    logic [16:0]          nfq;
    logic signed [PNT_W-1:0] plane49;
    logic [2:0][CW-1:0]   pt;
    logic [16:0]          fu;
    logic [16:0]          fv;
    t_res                 res;
    t_res                 last_res;
    logic                 out_free;
    logic                 out_load;

    function automatic logic [CW-1:0] sat(input logic signed [PNT_W-1:0] v);
        logic signed [PNT_W-1:0] vmax;
        logic signed [PNT_W-1:0] vmin;
        vmax = PNT_W'({1'b0, {(CW-1){1'b1}}});
        vmin = -vmax - PNT_W'(1);
        if (v > vmax) begin
            return {1'b0, {(CW-1){1'b1}}};
        end else if (v < vmin) begin
            return {1'b1, {(CW-1){1'b0}}};
        end
        return v[CW-1:0];
    endfunction

    always_comb begin
        a   = r_face[2:1];
        b   = (r_k == 1'b0) ? ((a == 2'd0) ? 2'd1 : 2'd0) : ((a == 2'd2) ? 2'd1 : 2'd2);
        trs = {r_rem, r_q[DIV_W-1]};
        tge = trs >= {1'b0, i_job.dmag[a]};
        nq  = {r_q[DIV_W-2:0], tge};

        lo49 = PNT_W'(i_box[b].lo);
        hi49 = PNT_W'(i_box[b].hi);
        p    = i_job.dneg[b] ?
               (PNT_W'($signed(i_job.org[b])) - $signed({2'b00, r_prod[2*CW-2:FB]})) :
               (PNT_W'($signed(i_job.org[b])) + $signed({2'b00, r_prod[2*CW-2:FB]}));
        in_box = (p >= lo49) && (p <= hi49);
        off    = p - lo49;
        sz     = {1'b0, i_box[b].size};
        ge0    = off[CW-1:0] >= sz;
        frs    = {r_fr, 1'b0};
        fge    = frs >= sz;
        nfq    = {r_fq[15:0], fge};

        plane49 = r_face[0] ? PNT_W'(i_box[a].hi) : PNT_W'(i_box[a].lo);
        for (int c = 0; c < 3; c++) begin
            pt[c] = (2'(c) == a) ? sat(plane49) : sat(r_p[c]);
        end
        case (t_face'(r_face))
            FACE_XMIN: begin fu = r_f[2];          fv = UV_ONE - r_f[1]; end
            FACE_XMAX: begin fu = UV_ONE - r_f[2]; fv = UV_ONE - r_f[1]; end
            FACE_YMIN: begin fu = UV_ONE - r_f[0]; fv = r_f[2];          end
            FACE_YMAX: begin fu = r_f[0];          fv = r_f[2];          end
            FACE_ZMIN: begin fu = UV_ONE - r_f[0]; fv = UV_ONE - r_f[1]; end
            default:   begin fu = r_f[0];          fv = UV_ONE - r_f[1]; end
        endcase
        res.hit     = 1'b1;
        res.face    = r_face;
        res.point_x = pt[0];
        res.point_y = pt[1];
        res.point_z = pt[2];
        res.tex_u   = fu;
        res.tex_v   = fv;
        res.last    = 1'b0;
        last_res      = r_pend_v ? r_pend : '0;
        last_res.last = 1'b1;
        out_free    = !r_ov || o_res.ready;
        out_load    = out_free &&
                      (((r_state == S_EMIT) && r_pend_v) || (r_state == S_DONE));
    end

    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;
    assign o_job_pop   = (r_state == S_DONE) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
            r_face   <= 3'd0;
            r_k      <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_face   <= 3'd0;
                        r_pend_v <= 1'b0;
                        r_state  <= S_FACE;
                    end
                end
                S_FACE: begin
                    if (i_job.skip[r_face]) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_q     <= {i_job.nmag[r_face], {FB{1'b0}}};
                        r_rem   <= '0;
                        r_cnt   <= 6'(DIV_W - 1);
                        r_k     <= 1'b0;
                        r_state <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    r_rem <= tge ? CW'(trs - {1'b0, i_job.dmag[a]}) : trs[CW-1:0];
                    r_q   <= nq;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_t     <= (nq > DIV_W'({(CW-1){1'b1}})) ? {(CW-1){1'b1}} : nq[CW-2:0];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_t * i_job.dmag[b];
                    r_state <= S_PNT;
                end
                S_PNT: begin
                    r_p[b] <= p;
                    if (!in_box) begin
                        r_state <= S_NEXT;
                    end else if (sz == '0 || off == '0) begin
                        r_f[b] <= '0;
                        r_k    <= 1'b1;
                        r_state <= r_k ? S_EMIT : S_MUL;
                    end else begin
                        r_fq    <= {16'd0, ge0};
                        r_fr    <= (CW-1)'(off[CW-1:0] - (ge0 ? sz : '0));
                        r_cnt   <= 6'd15;
                        r_state <= S_FDIV;
                    end
                end
                S_FDIV: begin
                    r_fr  <= fge ? (CW-1)'(frs - sz) : frs[CW-2:0];
                    r_fq  <= nfq;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_f[b]  <= nfq;
                        r_k     <= 1'b1;
                        r_state <= r_k ? S_EMIT : S_MUL;
                    end
                end
                S_EMIT: begin
                    if (!r_pend_v) begin
                        r_pend   <= res;
                        r_pend_v <= 1'b1;
                        r_state  <= S_NEXT;
                    end else if (out_free) begin
                        r_out   <= r_pend;
                        r_pend  <= res;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_face == 3'(FACE_ZMAX)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_face  <= r_face + 3'd1;
                        r_state <= S_FACE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out    <= last_res;
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> i_job_valid)
        else $error("job queue empty while a ray is in work");
    a_miss_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.data.hit) |-> o_res.data.last)
        else $error("miss item without last");
    a_uv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.data.tex_u <= UV_ONE && o_res.data.tex_v <= UV_ONE))
        else $error("texture coordinate out of range");
    a_pend_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("pending result left over between rays");
`endif
endmodule
`default_nettype wire
